>>> src/wpmt_pkg.sv
package wpmt_pkg;

	// Fixed field widths
	localparam int DATA_W   = 64;
	localparam int OFFSET_W = 19;
	localparam int BYTE_W   = OFFSET_W + 3;
	localparam int ERR_W    = 10;
	localparam int CFG_W    = 5;

	// Defaults for the top-level parameters
	localparam int WORDS_PER_LINE_DEF = 2;
	localparam int WORD_BITS_DEF      = 64;
	localparam int MAX_SIZE_LOG2_DEF  = 22;

	// Sequence constants
	localparam logic [CFG_W-1:0]  SIZE_LOG2_RESET = 5'd20;
	localparam logic [CFG_W-1:0]  SIZE_LOG2_MIN   = 5'd5;
	localparam int                ADDR_BIT_START  = 4;
	localparam logic [DATA_W-1:0] ADDR_INIT_DATA  = 64'h0003_0002_0001_0000;
	localparam logic [DATA_W-1:0] ADDR_INCREMENT  = 64'h0004_0004_0004_0004;
	localparam logic [BYTE_W-1:0] LINE_BYTE_MASK  = 22'h00000f;
	localparam logic [ERR_W-1:0]  ERR_MAX         = 10'd1023;

	localparam logic REGION_ARENA = 1'b0;
	localparam logic REGION_FLUSH = 1'b1;

	typedef enum logic [3:0] {
		PH_DATA1,
		PH_DATA0,
		PH_CLEAR,
		PH_A1W,
		PH_A1R,
		PH_A1C,
		PH_A0W,
		PH_A0R,
		PH_A0C,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_READ,
		KIND_FLUSH,
		KIND_DONE
	} kind_t;

	typedef enum logic [2:0] {
		TPH_DATA1,
		TPH_DATA0,
		TPH_ADDR1,
		TPH_ADDR0,
		TPH_CLEAR
	} tph_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  region;
		logic [OFFSET_W-1:0]   word_offset;
		logic [DATA_W-1:0]     pattern;
		tph_t                  test_phase;
		logic                  prev_mismatch;
		logic [ERR_W-1:0]      error_count;
		logic                  last;
	} access_t;

endpackage

>>> src/walking_pattern_memory_tester.sv
// An accepted word is registered in the input register; its access word is then registered
// into the result register and driven on the result ports, unless a stalled result holds it.
// Throughput: one word per cycle while out_stall is low; the sequencer state register updates once per step.
// The input register and the result register let a new word in while a result is stalled.
// Reset (arst_n low, asynchronous): both stages empty, cache size log2 back to 20,
// sequence at the start of the data walk, pending check and error count cleared.
module walking_pattern_memory_tester import wpmt_pkg::*; #(
	parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
	parameter int WORD_BITS      = WORD_BITS_DEF,
	parameter int MAX_SIZE_LOG2  = MAX_SIZE_LOG2_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [DATA_W-1:0]   read_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          access_kind,
	output logic                region,
	output logic [OFFSET_W-1:0] word_offset,
	output logic [DATA_W-1:0]   pattern,
	output logic [2:0]          test_phase,
	output logic                prev_mismatch,
	output logic [ERR_W-1:0]    error_count,
	output logic                last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data
);

	logic                valid_s1;
	logic                mode_s1;
	logic [DATA_W-1:0]   read_data_s1;
	logic                valid_s2;
	access_t             res_s2;
	access_t             res;
	logic [CFG_W-1:0]    size_log2_q;
	logic                out_load;
	logic                in_take;

	// Handshake between the two stages
	assign out_load  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !out_load;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= SIZE_LOG2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_log2_q <= cfg_data;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the input word and the finished access
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1      <= mode;
			read_data_s1 <= read_data;
		end
		if (out_load) begin
			res_s2 <= res;
		end
	end

	wpmt_core #(
		.WORDS_PER_LINE (WORDS_PER_LINE),
		.WORD_BITS      (WORD_BITS),
		.MAX_SIZE_LOG2  (MAX_SIZE_LOG2)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (out_load),
		.mode      (mode_s1),
		.read_data (read_data_s1),
		.size_log2 (size_log2_q),
		.res       (res)
	);

	// Drive the result ports
	assign out_valid     = valid_s2;
	assign access_kind   = res_s2.kind;
	assign region        = res_s2.region;
	assign word_offset   = res_s2.word_offset;
	assign pattern       = res_s2.pattern;
	assign test_phase    = res_s2.test_phase;
	assign prev_mismatch = res_s2.prev_mismatch;
	assign error_count   = res_s2.error_count;
	assign last          = res_s2.last;

`ifndef SYNTHESIS
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2)
		else $error("stalled result dropped");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.kind == KIND_DONE) |->
		res_s2.last && (res_s2.word_offset == '0) && (res_s2.pattern == '0))
		else $error("done access carries nonzero fields");

	a_mismatch_counted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.prev_mismatch |-> (res_s2.error_count != '0))
		else $error("mismatch reported with zero error count");
`endif

endmodule

>>> src/wpmt_core.sv
module wpmt_core import wpmt_pkg::*; #(
	parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
	parameter int WORD_BITS      = WORD_BITS_DEF,
	parameter int MAX_SIZE_LOG2  = MAX_SIZE_LOG2_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic              mode,
	input  logic [DATA_W-1:0] read_data,
	input  logic [CFG_W-1:0]  size_log2,
	output access_t           res
);

	localparam int SUB_LAST = 2 * WORDS_PER_LINE + 2;
	localparam int SUB_W    = $clog2(SUB_LAST + 1);
	localparam int LANE_W   = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
	localparam int BIT_W    = $clog2(WORD_BITS);
	localparam int ABIT_W   = $clog2(MAX_SIZE_LOG2 + 1);

	localparam logic [DATA_W-1:0] WMASK       = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);
	localparam logic [SUB_W-1:0]  SUB_WPL     = SUB_W'(WORDS_PER_LINE);
	localparam logic [SUB_W-1:0]  SUB_WPL_M1  = SUB_W'(WORDS_PER_LINE - 1);
	localparam logic [SUB_W-1:0]  SUB_FLUSH0  = SUB_W'(WORDS_PER_LINE + 1);
	localparam logic [SUB_W-1:0]  SUB_FLUSH1  = SUB_W'(WORDS_PER_LINE + 2);
	localparam logic [SUB_W-1:0]  SUB_RD0     = SUB_W'(WORDS_PER_LINE + 3);
	localparam logic [SUB_W-1:0]  SUB_END     = SUB_W'(SUB_LAST);
	localparam logic [LANE_W-1:0] LANE_END    = LANE_W'(WORDS_PER_LINE - 1);
	localparam logic [BIT_W-1:0]  BIT_END     = BIT_W'(WORD_BITS - 1);
	localparam logic [ABIT_W-1:0] ABIT_START  = ABIT_W'(ADDR_BIT_START);
	localparam logic [CFG_W-1:0]  SIZE_MAX_V  = CFG_W'(MAX_SIZE_LOG2);

	// Sequencer state
	phase_t              phase_q;
	logic [LANE_W-1:0]   lane_q;
	logic [BIT_W-1:0]    bit_q;
	logic [SUB_W-1:0]    sub_q;
	logic [ABIT_W-1:0]   abit_q;
	logic [DATA_W-1:0]   pat_q;
	logic                pend_chk_q;
	logic [DATA_W-1:0]   pend_exp_q;
	logic [ERR_W-1:0]    err_q;

	// State after an optional restart
	phase_t              cur_phase;
	logic [LANE_W-1:0]   cur_lane;
	logic [BIT_W-1:0]    cur_bit;
	logic [SUB_W-1:0]    cur_sub;
	logic [ABIT_W-1:0]   cur_abit;
	logic [DATA_W-1:0]   cur_pat;

	// State after skipping a finished address walk
	phase_t              e_phase;
	logic [SUB_W-1:0]    e_sub;
	logic [ABIT_W-1:0]   e_abit;
	logic [DATA_W-1:0]   e_pat;

	// Next state
	phase_t              n_phase;
	logic [LANE_W-1:0]   n_lane;
	logic [BIT_W-1:0]    n_bit;
	logic [SUB_W-1:0]    n_sub;
	logic [ABIT_W-1:0]   n_abit;
	logic [DATA_W-1:0]   n_pat;
	logic [ERR_W-1:0]    n_err;

	logic [ABIT_W-1:0]   size_eff;
	logic                mism;
	access_t             acc;

	// Clamp the configured size to the supported range
	always_comb begin
		if (size_log2 < SIZE_LOG2_MIN) begin
			size_eff = ABIT_W'(SIZE_LOG2_MIN);
		end else if (size_log2 > SIZE_MAX_V) begin
			size_eff = ABIT_W'(SIZE_MAX_V);
		end else begin
			size_eff = ABIT_W'(size_log2);
		end
	end

	// Restart the walk when mode is low
	always_comb begin
		if (mode) begin
			cur_phase = phase_q;
			cur_lane  = lane_q;
			cur_bit   = bit_q;
			cur_sub   = sub_q;
			cur_abit  = abit_q;
			cur_pat   = pat_q;
		end else begin
			cur_phase = PH_DATA1;
			cur_lane  = '0;
			cur_bit   = '0;
			cur_sub   = '0;
			cur_abit  = ABIT_START;
			cur_pat   = '0;
		end
	end

	// Advance past an address walk whose bit has reached the cache size
	always_comb begin
		e_phase = cur_phase;
		e_sub   = cur_sub;
		e_abit  = cur_abit;
		e_pat   = cur_pat;
		if ((cur_phase inside {[PH_A1W:PH_A0C]}) && (cur_abit >= size_eff)) begin
			e_sub  = '0;
			e_abit = ABIT_START;
			case (cur_phase)
				PH_A1W:  e_phase = PH_A1R;
				PH_A1R:  e_phase = PH_A1C;
				PH_A1C:  e_phase = PH_A0W;
				PH_A0W:  e_phase = PH_A0R;
				PH_A0R:  e_phase = PH_A0C;
				default: e_phase = PH_DONE;
			endcase
			e_pat = (e_phase == PH_A1R) ? ADDR_INIT_DATA : ~ADDR_INIT_DATA;
		end
	end

	// Compare returned data against the pending expectation
	always_comb begin
		mism = mode & pend_chk_q & (|((read_data ^ pend_exp_q) & WMASK));
		if (!mode) begin
			n_err = '0;
		end else if (mism && (err_q != ERR_MAX)) begin
			n_err = err_q + 1'b1;
		end else begin
			n_err = err_q;
		end
	end

	// Build the access for the current step
	always_comb begin
		logic                ones;
		logic [DATA_W-1:0]   bitv;
		logic [DATA_W-1:0]   fill;
		logic [DATA_W-1:0]   lanev;
		logic [SUB_W-1:0]    rd;
		logic [SUB_W-1:0]    lane_ext;
		logic [BYTE_W-1:0]   byte_off;
		logic [BYTE_W-1:0]   size_mask;
		ones      = (e_phase == PH_DATA1);
		bitv      = DATA_W'(1) << cur_bit;
		fill      = ones ? '0 : WMASK;
		lanev     = (ones ? bitv : ~bitv) & WMASK;
		rd        = cur_sub - SUB_RD0;
		lane_ext  = SUB_W'(cur_lane);
		size_mask = ~({BYTE_W{1'b1}} << size_eff) & ~LINE_BYTE_MASK;
		byte_off  = BYTE_W'(1) << e_abit;
		if (e_phase inside {[PH_A0W:PH_A0C]}) begin
			byte_off = ~byte_off & size_mask;
		end

		acc             = '0;
		acc.kind        = KIND_WRITE;
		acc.region      = REGION_ARENA;
		acc.test_phase  = TPH_CLEAR;
		case (e_phase)
			PH_DATA1, PH_DATA0: begin
				acc.test_phase = ones ? TPH_DATA1 : TPH_DATA0;
				if (cur_sub < SUB_WPL) begin
					acc.word_offset = OFFSET_W'(cur_sub);
					acc.pattern     = fill;
				end else if (cur_sub == SUB_WPL) begin
					acc.word_offset = OFFSET_W'(cur_lane);
					acc.pattern     = lanev;
				end else if (cur_sub == SUB_FLUSH0) begin
					acc.kind   = KIND_FLUSH;
					acc.region = REGION_FLUSH;
				end else if (cur_sub == SUB_FLUSH1) begin
					acc.kind        = KIND_FLUSH;
					acc.region      = REGION_FLUSH;
					acc.word_offset = OFFSET_W'(1) << (size_eff - ABIT_START);
				end else begin
					acc.kind = KIND_READ;
					if (rd < SUB_WPL_M1) begin
						acc.word_offset = (rd < lane_ext) ? OFFSET_W'(rd)
							: OFFSET_W'(rd + 1'b1);
						acc.pattern     = fill;
					end else begin
						acc.word_offset = OFFSET_W'(cur_lane);
						acc.pattern     = lanev;
					end
				end
			end
			PH_CLEAR: begin
				acc.word_offset = OFFSET_W'(cur_sub);
			end
			PH_A1W, PH_A1R, PH_A1C, PH_A0W, PH_A0R, PH_A0C: begin
				acc.word_offset = byte_off[BYTE_W-1:3] | OFFSET_W'(e_sub[0]);
				if (e_phase == PH_A1C || e_phase == PH_A0C) begin
					acc.test_phase = TPH_CLEAR;
				end else begin
					acc.test_phase = (e_phase inside {PH_A1W, PH_A1R}) ? TPH_ADDR1
						: TPH_ADDR0;
					acc.pattern    = e_pat & WMASK;
					acc.kind       = (e_phase inside {PH_A1R, PH_A0R}) ? KIND_READ
						: KIND_WRITE;
				end
			end
			default: begin
				acc.kind = KIND_DONE;
			end
		endcase
		acc.last          = (acc.kind == KIND_DONE);
		acc.prev_mismatch = mism;
		acc.error_count   = n_err;
	end

	assign res = acc;

	// Next state of the walk
	always_comb begin
		n_phase = e_phase;
		n_lane  = cur_lane;
		n_bit   = cur_bit;
		n_sub   = e_sub;
		n_abit  = e_abit;
		n_pat   = e_pat;
		case (e_phase)
			PH_DATA1, PH_DATA0: begin
				if (cur_sub == SUB_END) begin
					n_sub = '0;
					if (cur_bit == BIT_END) begin
						n_bit = '0;
						if (e_phase == PH_DATA1) begin
							n_phase = PH_DATA0;
						end else if (cur_lane == LANE_END) begin
							n_lane  = '0;
							n_phase = PH_CLEAR;
						end else begin
							n_lane  = cur_lane + 1'b1;
							n_phase = PH_DATA1;
						end
					end else begin
						n_bit = cur_bit + 1'b1;
					end
				end else begin
					n_sub = cur_sub + 1'b1;
				end
			end
			PH_CLEAR: begin
				if (cur_sub == SUB_WPL_M1) begin
					n_phase = PH_A1W;
					n_sub   = '0;
					n_abit  = ABIT_START;
					n_pat   = ADDR_INIT_DATA;
				end else begin
					n_sub = cur_sub + 1'b1;
				end
			end
			PH_A1W, PH_A1R, PH_A1C, PH_A0W, PH_A0R, PH_A0C: begin
				if (e_phase inside {PH_A1W, PH_A1R}) begin
					n_pat = e_pat + ADDR_INCREMENT;
				end else if (e_phase inside {PH_A0W, PH_A0R}) begin
					n_pat = e_pat - ADDR_INCREMENT;
				end
				if (e_sub[0]) begin
					n_sub  = '0;
					n_abit = e_abit + 1'b1;
				end else begin
					n_sub = SUB_W'(1);
				end
			end
			default: begin
				n_phase = PH_DONE;
			end
		endcase
	end

	// Hold state between steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DATA1;
			lane_q     <= '0;
			bit_q      <= '0;
			sub_q      <= '0;
			abit_q     <= ABIT_START;
			pend_chk_q <= 1'b0;
			err_q      <= '0;
		end else if (step_en) begin
			phase_q    <= n_phase;
			lane_q     <= n_lane;
			bit_q      <= n_bit;
			sub_q      <= n_sub;
			abit_q     <= n_abit;
			pend_chk_q <= (acc.kind == KIND_READ);
			err_q      <= n_err;
		end
	end

	// Pattern and expectation words
	always_ff @(posedge clk) begin
		if (step_en) begin
			pat_q <= n_pat;
			if (acc.kind == KIND_READ) begin
				pend_exp_q <= acc.pattern;
			end
		end
	end

`ifndef SYNTHESIS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode && (phase_q == PH_DONE) |=> (phase_q == PH_DONE))
		else $error("done state left without a restart");

	a_err_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode |=> (err_q >= $past(err_q)))
		else $error("error count decreased while advancing");

	a_pend_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> (pend_chk_q == ($past(acc.kind) == KIND_READ)))
		else $error("pending check does not match last access kind");
`endif

endmodule

>>> tb/walking_pattern_memory_tester_tb.sv
module walking_pattern_memory_tester_tb;
	import wpmt_pkg::*;

	localparam logic MODE_RESTART = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;
	localparam int   DIR_ROWS         = 24;
	localparam int   LONG_HOLD_CYCLES = 300;
	localparam int   WATCHDOG_LIMIT   = 2000;
	localparam int   SETTLE_CYCLES    = 4;

	// Software view of the sequencer
	typedef struct packed {
		phase_t              ph;
		logic [3:0]          lane;
		logic [6:0]          bitpos;
		logic [3:0]          sub;
		logic [4:0]          abit;
		logic [DATA_W-1:0]   pat;
		logic [DATA_W-1:0]   chk_value;
		logic                chk_pending;
		logic [ERR_W-1:0]    errs;
		logic [CFG_W-1:0]    size_log2;
	} walk_state_t;

	typedef struct packed {
		logic    typed;
		access_t acc;
	} access_note_t;

	typedef struct packed {
		logic              m;
		logic [DATA_W-1:0] rd;
		logic              typed;
		access_t           acc;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                mode;
	logic [DATA_W-1:0]   read_data;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          access_kind;
	logic                region;
	logic [OFFSET_W-1:0] word_offset;
	logic [DATA_W-1:0]   pattern;
	logic [2:0]          test_phase;
	logic                prev_mismatch;
	logic [ERR_W-1:0]    error_count;
	logic                last;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;

	walk_state_t  model_st;
	walk_state_t  sender_st;
	access_t      access_fifo[$];
	access_note_t access_note_q[$];

	int   fail_count     = 0;
	int   words_sent     = 0;
	int   words_checked  = 0;
	int   restarts_seen  = 0;
	int   mismatch_flags = 0;
	int   done_words     = 0;
	int   sizes_written  = 0;
	int   deepest_phase  = 0;
	int   idle_cycles    = 0;
	logic quiet_run      = 1'b0;
	logic send_gaps      = 1'b1;
	logic recv_bursts    = 1'b1;
	logic long_hold_req  = 1'b0;

	walking_pattern_memory_tester i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.read_data     (read_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.access_kind   (access_kind),
		.region        (region),
		.word_offset   (word_offset),
		.pattern       (pattern),
		.test_phase    (test_phase),
		.prev_mismatch (prev_mismatch),
		.error_count   (error_count),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic walk_state_t fresh_walk();
		walk_state_t st;
		st = '0;
		st.ph = PH_DATA1;
		st.abit = ADDR_BIT_START;
		st.size_log2 = SIZE_LOG2_RESET;
		return st;
	endfunction

	function automatic walk_state_t begin_addr_walk(walk_state_t st, phase_t p);
		st.ph = p;
		st.sub = '0;
		st.abit = ADDR_BIT_START;
		st.pat = (p == PH_A1W || p == PH_A1R) ? ADDR_INIT_DATA : ~ADDR_INIT_DATA;
		return st;
	endfunction

	function automatic access_t access_of(kind_t k, logic rgn, logic [DATA_W-1:0] off,
			logic [DATA_W-1:0] pat, tph_t t);
		access_t acc;
		acc = '0;
		acc.kind = k;
		acc.region = rgn;
		acc.word_offset = off[OFFSET_W-1:0];
		acc.pattern = pat;
		acc.test_phase = t;
		acc.last = (k == KIND_DONE);
		return acc;
	endfunction

	// Advance the walk by one command word and produce the access it yields
	task automatic walk_step(inout walk_state_t st, input logic m,
			input logic [DATA_W-1:0] rd, output access_t acc);
		int                l;
		int                r;
		int                wd;
		int                grp;
		logic              ones;
		logic              up;
		logic              mism;
		logic [CFG_W-1:0]  sz;
		logic [DATA_W-1:0] bitv;
		logic [DATA_W-1:0] fill;
		logic [DATA_W-1:0] lanev;
		logic [DATA_W-1:0] off;
		logic [DATA_W-1:0] msk;
		tph_t              tph;
		mism = 1'b0;
		// restart, or score the previous checked read
		if (m == MODE_RESTART) begin
			sz = st.size_log2;
			st = fresh_walk();
			st.size_log2 = sz;
		end else if (st.chk_pending && rd != st.chk_value) begin
			mism = 1'b1;
			if (st.errs != ERR_MAX) st.errs++;
		end
		l = int'(st.size_log2);
		if (l < int'(SIZE_LOG2_MIN)) l = int'(SIZE_LOG2_MIN);
		if (l > MAX_SIZE_LOG2_DEF) l = MAX_SIZE_LOG2_DEF;
		st.chk_pending = 1'b0;
		if (st.ph == PH_DATA1 || st.ph == PH_DATA0) begin
			// data walk: fill, lane write, two flushes, check others then lane
			ones = (st.ph == PH_DATA1);
			bitv = 64'd1 << st.bitpos;
			fill = ones ? '0 : '1;
			lanev = ones ? bitv : ~bitv;
			tph = ones ? TPH_DATA1 : TPH_DATA0;
			if (st.sub < WORDS_PER_LINE_DEF) begin
				acc = access_of(KIND_WRITE, REGION_ARENA, DATA_W'(st.sub), fill, tph);
			end else if (st.sub == WORDS_PER_LINE_DEF) begin
				acc = access_of(KIND_WRITE, REGION_ARENA, DATA_W'(st.lane), lanev, tph);
			end else if (st.sub == WORDS_PER_LINE_DEF + 1) begin
				acc = access_of(KIND_FLUSH, REGION_FLUSH, '0, '0, tph);
			end else if (st.sub == WORDS_PER_LINE_DEF + 2) begin
				acc = access_of(KIND_FLUSH, REGION_FLUSH, 64'd1 << (l - 4), '0, tph);
			end else begin
				r = int'(st.sub) - (WORDS_PER_LINE_DEF + 3);
				if (r + 1 < WORDS_PER_LINE_DEF) begin
					wd = (r < int'(st.lane)) ? r : r + 1;
					acc = access_of(KIND_READ, REGION_ARENA, DATA_W'(wd), fill, tph);
					st.chk_value = fill;
				end else begin
					acc = access_of(KIND_READ, REGION_ARENA, DATA_W'(st.lane), lanev, tph);
					st.chk_value = lanev;
				end
				st.chk_pending = 1'b1;
			end
			st.sub++;
			if (st.sub >= 2 * WORDS_PER_LINE_DEF + 3) begin
				st.sub = '0;
				st.bitpos++;
				if (st.bitpos >= WORD_BITS_DEF) begin
					st.bitpos = '0;
					if (ones) begin
						st.ph = PH_DATA0;
					end else begin
						st.ph = PH_DATA1;
						st.lane++;
						if (st.lane >= WORDS_PER_LINE_DEF) begin
							st.lane = '0;
							st.ph = PH_CLEAR;
						end
					end
				end
			end
		end else if (st.ph == PH_CLEAR) begin
			acc = access_of(KIND_WRITE, REGION_ARENA, DATA_W'(st.sub), '0, TPH_CLEAR);
			st.sub++;
			if (st.sub >= WORDS_PER_LINE_DEF) st = begin_addr_walk(st, PH_A1W);
		end else begin
			// skip address walks whose bit already reached the current size
			while (st.ph >= PH_A1W && st.ph <= PH_A0C && st.abit >= l) begin
				if (st.ph == PH_A0C) st.ph = PH_DONE;
				else st = begin_addr_walk(st, phase_t'(st.ph + 1));
			end
			if (st.ph >= PH_A1W && st.ph <= PH_A0C) begin
				grp = int'(st.ph - PH_A1W) % 3;
				up = (st.ph <= PH_A1C);
				off = 64'd1 << st.abit;
				if (!up) begin
					msk = (64'd1 << l) - 64'd1;
					msk[3:0] = '0;
					off = ~off & msk;
				end
				off = (off >> 3) + DATA_W'(st.sub);
				tph = (grp == 2) ? TPH_CLEAR : (up ? TPH_ADDR1 : TPH_ADDR0);
				if (grp == 2) begin
					acc = access_of(KIND_WRITE, REGION_ARENA, off, '0, tph);
				end else if (grp == 0) begin
					acc = access_of(KIND_WRITE, REGION_ARENA, off, st.pat, tph);
				end else begin
					acc = access_of(KIND_READ, REGION_ARENA, off, st.pat, tph);
					st.chk_value = st.pat;
					st.chk_pending = 1'b1;
				end
				if (grp != 2) st.pat = up ? st.pat + ADDR_INCREMENT : st.pat - ADDR_INCREMENT;
				st.sub++;
				if (st.sub >= 2) begin
					st.sub = '0;
					st.abit++;
				end
			end else begin
				st.ph = PH_DONE;
				acc = access_of(KIND_DONE, REGION_ARENA, '0, '0, TPH_CLEAR);
			end
		end
		acc.prev_mismatch = mism;
		acc.error_count = st.errs;
	endtask

	task automatic check_access(input access_t want, input access_t got);
		logic bad;
		bad = 1'b0;
		if (got.kind != want.kind) begin
			$error("access_kind: expected %0d, got %0d", want.kind, got.kind);
			bad = 1'b1;
		end
		if (got.region != want.region) begin
			$error("region: expected %0d, got %0d", want.region, got.region);
			bad = 1'b1;
		end
		if (got.word_offset != want.word_offset) begin
			$error("word_offset: expected %0d, got %0d", want.word_offset, got.word_offset);
			bad = 1'b1;
		end
		if (got.pattern != want.pattern) begin
			$error("pattern: expected %h, got %h", want.pattern, got.pattern);
			bad = 1'b1;
		end
		if (got.test_phase != want.test_phase) begin
			$error("test_phase: expected %0d, got %0d", want.test_phase, got.test_phase);
			bad = 1'b1;
		end
		if (got.prev_mismatch != want.prev_mismatch) begin
			$error("prev_mismatch: expected %0d, got %0d", want.prev_mismatch,
				got.prev_mismatch);
			bad = 1'b1;
		end
		if (got.error_count != want.error_count) begin
			$error("error_count: expected %0d, got %0d", want.error_count, got.error_count);
			bad = 1'b1;
		end
		if (got.last != want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			bad = 1'b1;
		end
		if (bad) fail_count++;
	endtask

	// Score output words, record accepted commands and size writes, watch for a hang
	always @(posedge clk) begin : monitor
		access_t      got;
		access_t      pred;
		access_note_t note;
		logic         moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = '0;
				got.kind = kind_t'(access_kind);
				got.region = region;
				got.word_offset = word_offset;
				got.pattern = pattern;
				got.test_phase = tph_t'(test_phase);
				got.prev_mismatch = prev_mismatch;
				got.error_count = error_count;
				got.last = last;
				if (prev_mismatch) mismatch_flags++;
				if (got.kind == KIND_DONE) done_words++;
				if (access_fifo.size() == 0) begin
					$error("access word with nothing pending: kind %0d offset %0d",
						access_kind, word_offset);
					fail_count++;
				end else begin
					check_access(access_fifo.pop_front(), got);
				end
				words_checked++;
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				if (mode == MODE_RESTART) restarts_seen++;
				walk_step(model_st, mode, read_data, pred);
				if (int'(model_st.ph) > deepest_phase) deepest_phase = int'(model_st.ph);
				note = access_note_q.pop_front();
				access_fifo.push_back(note.typed ? note.acc : pred);
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				model_st.size_log2 = cfg_data;
				sizes_written++;
			end
			if (moved) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[walking_pattern_memory_tester] ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (!quiet_run && recv_bursts && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
			if ($urandom_range(0, 99) == 0) recv_bursts = !recv_bursts;
		end
	end

	// Offer one command word and hold it until accepted, then maybe go idle
	task automatic offer_word(input logic m, input logic [DATA_W-1:0] rd,
			input logic typed, input access_t acc);
		access_t unused;
		walk_step(sender_st, m, rd, unused);
		access_note_q.push_back({typed, acc});
		in_valid <= 1'b1;
		mode <= m;
		read_data <= rd;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (!quiet_run && send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		if ($urandom_range(0, 99) == 0) send_gaps = !send_gaps;
	endtask

	// Drain the block, then write the cache size
	task automatic set_cache_size(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (access_fifo.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sender_st.size_log2 = v;
	endtask

	// Random commands: mostly correct read answers, some corrupted, rare restarts
	task automatic run_segment(input logic [CFG_W-1:0] size, input int count,
			input logic restart_first, input int restart_odds, input logic calm,
			input int hold_at);
		int                n;
		logic              m;
		logic [DATA_W-1:0] rd;
		set_cache_size(size);
		quiet_run = calm;
		for (n = 0; n < count; n++) begin
			if (n == hold_at) long_hold_req = 1'b1;
			m = MODE_ADVANCE;
			if ((n == 0 && restart_first) ||
					(restart_odds != 0 && $urandom_range(1, restart_odds) == 1))
				m = MODE_RESTART;
			if (m == MODE_ADVANCE && sender_st.chk_pending) begin
				case ($urandom_range(0, 15))
					0: rd = sender_st.chk_value ^ (64'd1 << $urandom_range(0, 63));
					1: rd = {$urandom, $urandom};
					2: rd = ~sender_st.chk_value;
					default: rd = sender_st.chk_value;
				endcase
			end else begin
				rd = {$urandom, $urandom};
			end
			offer_word(m, rd, 1'b0, '0);
		end
	endtask

	function automatic dir_row_t typed_row(logic m, logic [DATA_W-1:0] rd, kind_t k,
			logic rgn, logic [DATA_W-1:0] off, logic [DATA_W-1:0] pat, tph_t t,
			logic mism, logic [ERR_W-1:0] err);
		dir_row_t row;
		row.m = m;
		row.rd = rd;
		row.typed = 1'b1;
		row.acc = access_of(k, rgn, off, pat, t);
		row.acc.prev_mismatch = mism;
		row.acc.error_count = err;
		return row;
	endfunction

	function automatic dir_row_t free_row(logic m, logic [DATA_W-1:0] rd);
		dir_row_t row;
		row = '0;
		row.m = m;
		row.rd = rd;
		return row;
	endfunction

	initial begin : stimulus
		dir_row_t dir_tab [DIR_ROWS];
		int       i;
		model_st = fresh_walk();
		sender_st = fresh_walk();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_RESTART;
		read_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: advance before any restart, first bit of the data walk with a
		// missed check, restart clearing the error count, then read-data extremes
		dir_tab[0]  = typed_row(MODE_ADVANCE, '1, KIND_WRITE, REGION_ARENA, '0, '0,
			TPH_DATA1, 1'b0, '0);
		dir_tab[1]  = typed_row(MODE_RESTART, '0, KIND_WRITE, REGION_ARENA, '0, '0,
			TPH_DATA1, 1'b0, '0);
		dir_tab[2]  = typed_row(MODE_ADVANCE, '1, KIND_WRITE, REGION_ARENA, 64'd1, '0,
			TPH_DATA1, 1'b0, '0);
		dir_tab[3]  = typed_row(MODE_ADVANCE, '0, KIND_WRITE, REGION_ARENA, '0, 64'h1,
			TPH_DATA1, 1'b0, '0);
		dir_tab[4]  = typed_row(MODE_ADVANCE, '1, KIND_FLUSH, REGION_FLUSH, '0, '0,
			TPH_DATA1, 1'b0, '0);
		dir_tab[5]  = typed_row(MODE_ADVANCE, '0, KIND_FLUSH, REGION_FLUSH, 64'h10000, '0,
			TPH_DATA1, 1'b0, '0);
		dir_tab[6]  = typed_row(MODE_ADVANCE, '0, KIND_READ, REGION_ARENA, 64'd1, '0,
			TPH_DATA1, 1'b0, '0);
		dir_tab[7]  = typed_row(MODE_ADVANCE, '0, KIND_READ, REGION_ARENA, '0, 64'h1,
			TPH_DATA1, 1'b0, '0);
		dir_tab[8]  = typed_row(MODE_ADVANCE, '0, KIND_WRITE, REGION_ARENA, '0, '0,
			TPH_DATA1, 1'b1, 10'd1);
		dir_tab[9]  = typed_row(MODE_ADVANCE, '1, KIND_WRITE, REGION_ARENA, 64'd1, '0,
			TPH_DATA1, 1'b0, 10'd1);
		dir_tab[10] = typed_row(MODE_ADVANCE, '0, KIND_WRITE, REGION_ARENA, '0, 64'h2,
			TPH_DATA1, 1'b0, 10'd1);
		dir_tab[11] = typed_row(MODE_RESTART, '1, KIND_WRITE, REGION_ARENA, '0, '0,
			TPH_DATA1, 1'b0, '0);
		dir_tab[12] = free_row(MODE_ADVANCE, '1);
		dir_tab[13] = free_row(MODE_ADVANCE, '0);
		dir_tab[14] = free_row(MODE_ADVANCE, 64'h8000_0000_0000_0000);
		dir_tab[15] = free_row(MODE_ADVANCE, 64'h1);
		dir_tab[16] = free_row(MODE_ADVANCE, '0);
		dir_tab[17] = free_row(MODE_ADVANCE, '1);
		dir_tab[18] = free_row(MODE_ADVANCE, 64'h1);
		dir_tab[19] = free_row(MODE_ADVANCE, 64'h5555_5555_5555_5555);
		dir_tab[20] = free_row(MODE_ADVANCE, 64'hAAAA_AAAA_AAAA_AAAA);
		dir_tab[21] = free_row(MODE_ADVANCE, 64'h8000_0000_0000_0000);
		dir_tab[22] = free_row(MODE_RESTART, '0);
		dir_tab[23] = free_row(MODE_ADVANCE, '1);
		for (i = 0; i < DIR_ROWS; i++)
			offer_word(dir_tab[i].m, dir_tab[i].rd, dir_tab[i].typed, dir_tab[i].acc);

		// Data walk at the largest size with a long receiver hold-off, then change
		// the size mid-walk, then noisy runs at clamped sizes and a last one at size 13 without idling
		run_segment(5'd22, 330, 1'b1, 0, 1'b0, 100);
		run_segment(5'd8, 120, 1'b0, 0, 1'b0, -1);
		run_segment(5'd0, 130, 1'b1, 40, 1'b0, -1);
		run_segment(5'd31, 110, 1'b1, 60, 1'b0, -1);
		run_segment(5'd13, 130, 1'b1, 80, 1'b1, -1);

		// Drain and settle
		in_valid <= 1'b0;
		@(posedge clk);
		while (access_fifo.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (access_fifo.size() != 0) begin
			$error("%0d access words never arrived", access_fifo.size());
			fail_count++;
		end

		$display("Sent %0d command words (%0d restarts) over %0d cache sizes; checked %0d accesses.",
			words_sent, restarts_seen, sizes_written, words_checked);
		$display("Saw %0d flagged read mismatches and %0d done words; deepest walk phase %0d.",
			mismatch_flags, done_words, deepest_phase);
		if (fail_count == 0) begin
			$display("[walking_pattern_memory_tester] OK");
		end else begin
			$display("[walking_pattern_memory_tester] ERROR");
		end
		$finish;
	end

endmodule

>>> walking_pattern_memory_tester.f
src/wpmt_pkg.sv
src/wpmt_core.sv
src/walking_pattern_memory_tester.sv
tb/walking_pattern_memory_tester_tb.sv
